// ===== rtl/core/lhf_pkg.sv =====
`default_nettype none
package lhf_pkg;

  // Fixed field widths of the ports.
  localparam int DATA_W = 12;
  localparam int TS_W   = 32;

  // Default geometry of the averaging window.
  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DARK   = 1'b1;

  // Threshold reset values.
  localparam logic [DATA_W-1:0] BRIGHT_RST = 12'd1000;
  localparam logic [DATA_W-1:0] DARK_RST   = 12'd3000;

endpackage
`default_nettype wire

// ===== rtl/core/lhf_in_if.sv =====
`default_nettype none
interface lhf_in_if;
  import lhf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, output sample, output timestamp, input ready);
  modport sink   (input valid, input sample, input timestamp, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lhf_out_if.sv =====
`default_nettype none
interface lhf_out_if;
  import lhf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] raw_value;
  logic [DATA_W-1:0] mean_value;
  logic              is_bright;
  logic              level_changed;
  logic [TS_W-1:0]   transition_time;

  modport source (
    output valid, output raw_value, output mean_value, output is_bright,
    output level_changed, output transition_time, input ready
  );
  modport sink (
    input valid, input raw_value, input mean_value, input is_bright,
    input level_changed, input transition_time, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/light_level_hysteresis_filter_unit.sv =====
// An accepted item passes ST_READ, which commits it to the window, then ST_DIV, where the
// one-bit-per-cycle restoring divider forms the mean from sum and fill count, then ST_DONE,
// which loads the output register once it is free; a new item is taken only after that.
// A finished result waits in the output register while the next item is worked on.
// Reset (rst_n low, synchronous) empties the window, selects dark, clears the transition
// time and loads the threshold defaults; the sample memory itself is not cleared.
`default_nettype none
module light_level_hysteresis_filter_unit #(
  parameter int WINDOW      = lhf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = lhf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lhf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lhf_pkg::DATA_W-1:0]     cfg_wdata,
  lhf_in_if.sink                              in_ch,
  lhf_out_if.source                           out_ch
);
  import lhf_pkg::*;

  // Sample bits actually used, window geometry and derived widths.
  localparam int USE_W  = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = USE_W + CNT_W;
  localparam int STEP_W = $clog2(USE_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic               level_r;
  logic [TS_W-1:0]    time_r;
  logic [DATA_W-1:0]  bright_thr_r;
  logic [DATA_W-1:0]  dark_thr_r;

  // Item held while it is worked on.
  logic [USE_W-1:0]   smp_r;
  logic [TS_W-1:0]    ts_r;

  // Divider state: partial remainder, dividend/quotient shifter, step count.
  logic [CNT_W-1:0]   rem_r;
  logic [USE_W-1:0]   quo_r;
  logic [STEP_W-1:0]  step_r;

  // Output register.
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_raw_r;
  logic [DATA_W-1:0]  out_mean_r;
  logic               out_bright_r;
  logic               out_changed_r;
  logic [TS_W-1:0]    out_time_r;

  // Sample ring memory.
  logic [USE_W-1:0]   ring_mem [WINDOW];
  logic [USE_W-1:0]   ring_rd_r;
  logic               ring_we;

  logic               in_acc;
  logic               full;
  logic [SUM_W-1:0]   sum_nxt;
  logic [POS_W-1:0]   pos_nxt;
  logic [CNT_W:0]     div_trial;
  logic               div_bit;
  logic [CNT_W-1:0]   rem_nxt;
  logic [DATA_W-1:0]  mean;
  logic               level_nxt;
  logic               out_free;

  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);
  assign full     = (cnt_r == CNT_W'(WINDOW));
  assign ring_we  = (state_r == ST_READ);
  assign out_free = !out_valid_r || out_ch.ready;

  // Sum update: drop the overwritten sample once the window is full.
  always_comb begin
    sum_nxt = sum_r + SUM_W'(smp_r);
    if (full) begin
      sum_nxt = sum_nxt - SUM_W'(ring_rd_r);
    end
    pos_nxt = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
  end

  // One restoring division step per cycle.
  always_comb begin
    div_trial = {rem_r, quo_r[USE_W-1]};
    div_bit   = (div_trial >= {1'b0, cnt_r});
    if (div_bit) begin
      rem_nxt = CNT_W'(div_trial - {1'b0, cnt_r});
    end else begin
      rem_nxt = div_trial[CNT_W-1:0];
    end
  end

  // Hysteresis decision; the bright test wins when both hold.
  always_comb begin
    mean      = DATA_W'(quo_r);
    level_nxt = level_r;
    if (mean <= bright_thr_r) begin
      level_nxt = 1'b1;
    end else if (mean >= dark_thr_r) begin
      level_nxt = 1'b0;
    end
  end

  // Ring memory: read the slot about to be replaced, write it in the following cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_rd_r <= ring_mem[pos_r];
    end
    if (ring_we) begin
      ring_mem[pos_r] <= smp_r;
    end
  end

  // Sequencer, window state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      level_r      <= 1'b0;
      time_r       <= '0;
      bright_thr_r <= BRIGHT_RST;
      dark_thr_r   <= DARK_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BRIGHT: bright_thr_r <= cfg_wdata;
          REG_DARK:   dark_thr_r   <= cfg_wdata;
          default:    ;
        endcase
      end

      // A result leaving in the cycle a new one is loaded is handled in ST_DONE.
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            smp_r   <= in_ch.sample[USE_W-1:0];
            ts_r    <= in_ch.timestamp;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          // Commit the new sample and set up the divider.
          sum_r   <= sum_nxt;
          pos_r   <= pos_nxt;
          if (!full) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          rem_r   <= sum_nxt[SUM_W-1:USE_W];
          quo_r   <= sum_nxt[USE_W-1:0];
          step_r  <= STEP_W'(USE_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[USE_W-2:0], div_bit};
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            level_r       <= level_nxt;
            out_valid_r   <= 1'b1;
            out_raw_r     <= DATA_W'(smp_r);
            out_mean_r    <= mean;
            out_bright_r  <= level_nxt;
            out_changed_r <= (level_nxt != level_r);
            if (level_nxt != level_r) begin
              time_r     <= ts_r;
              out_time_r <= ts_r;
            end else begin
              out_time_r <= time_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.raw_value       = out_raw_r;
  assign out_ch.mean_value      = out_mean_r;
  assign out_ch.is_bright       = out_bright_r;
  assign out_ch.level_changed   = out_changed_r;
  assign out_ch.transition_time = out_time_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lhf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // One input item and one result item as the filter sees them.
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [TS_W-1:0]   stamp;
  } light_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] raw_value;
    logic [DATA_W-1:0] mean_value;
    logic              is_bright;
    logic              level_changed;
    logic [TS_W-1:0]   transition_time;
  } level_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  lhf_in_if  in_ch();
  lhf_out_if out_ch();

  light_level_hysteresis_filter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Queues between stimulus, driver and checker.
  light_item_t samples_to_send[$];
  level_item_t expected_levels[$];
  light_item_t next_item;

  // Handshake pressure, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Run statistics.
  int n_errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_changes = 0;
  int n_settings = 0;
  int cycle_count = 0;

  // Private copy of the filter state and its thresholds.
  logic [DATA_W-1:0] window_copy [WINDOW_DEF];
  int               slot_next = 0;
  int               samples_held = 0;
  logic [15:0]      window_sum = '0;
  logic             bright_now = 1'b0;
  logic [TS_W-1:0]  last_change = '0;
  logic [DATA_W-1:0] bright_thr = BRIGHT_RST;
  logic [DATA_W-1:0] dark_thr = DARK_RST;

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Push one sample into the window, form the mean and apply the hysteresis.
  function automatic level_item_t average_and_classify(light_item_t item);
    level_item_t res;
    logic        was_bright;
    logic [31:0] mean;
    was_bright = bright_now;
    if (samples_held >= WINDOW_DEF) begin
      window_sum = window_sum - window_copy[slot_next];
    end else begin
      samples_held++;
    end
    window_copy[slot_next] = item.sample;
    window_sum = window_sum + item.sample;
    slot_next = (slot_next == WINDOW_DEF - 1) ? 0 : slot_next + 1;
    mean = window_sum / samples_held;
    // The bright test goes first, so it wins when the thresholds overlap.
    if (mean <= bright_thr) begin
      bright_now = 1'b1;
    end else if (mean >= dark_thr) begin
      bright_now = 1'b0;
    end
    if (bright_now != was_bright) begin
      last_change = item.stamp;
    end
    res.raw_value = item.sample;
    res.mean_value = mean[DATA_W-1:0];
    res.is_bright = bright_now;
    res.level_changed = (bright_now != was_bright);
    res.transition_time = last_change;
    return res;
  endfunction

  // Compare one result item with the oldest expectation.
  task automatic check_level(level_item_t got);
    level_item_t want;
    if (expected_levels.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("ERROR: unexpected result raw=%0d filtered=%0d", got.raw_value,
                 got.mean_value);
      end
    end else begin
      want = expected_levels.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("ERROR: result %0d mismatch", n_results);
          $display("  expected raw=%0d filtered=%0d bright=%0b changed=%0b time=%h",
                   want.raw_value, want.mean_value, want.is_bright,
                   want.level_changed, want.transition_time);
          $display("  actual   raw=%0d filtered=%0d bright=%0b changed=%0b time=%h",
                   got.raw_value, got.mean_value, got.is_bright,
                   got.level_changed, got.transition_time);
        end
      end
    end
  endtask

  // Driver: presents queued items, predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_levels.push_back(average_and_classify({in_ch.sample, in_ch.timestamp}));
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = samples_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.sample <= next_item.sample;
          in_ch.timestamp <= next_item.stamp;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and checking of every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.level_changed) begin
          n_changes++;
        end
        check_level({out_ch.raw_value, out_ch.mean_value, out_ch.is_bright,
                     out_ch.level_changed, out_ch.transition_time});
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_item(logic [DATA_W-1:0] sample, logic [TS_W-1:0] stamp);
    samples_to_send.push_back({sample, stamp});
  endtask

  // Wait until every item has gone through and the filter is idle.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (samples_to_send.size() != 0 || in_ch.valid || expected_levels.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BRIGHT) begin
      bright_thr = value;
    end else begin
      dark_thr = value;
    end
  endtask

  // Random runs of samples: each run dwells in one region so the mean
  // actually crosses the thresholds, with uniform noise mixed in.
  task automatic queue_random(int count);
    int run_len;
    int region;
    int lo;
    int hi;
    int center;
    logic [DATA_W-1:0] sample;
    while (count > 0) begin
      run_len = $urandom_range(3, 14);
      region = $urandom_range(0, 5);
      case (region)
        0: begin
          lo = 0;
          hi = 300;
        end
        1: begin
          lo = 3800;
          hi = 4095;
        end
        2, 3: begin
          center = (region == 2) ? int'(bright_thr) : int'(dark_thr);
          lo = (center < 150) ? 0 : center - 150;
          hi = (center > 3945) ? 4095 : center + 150;
        end
        default: begin
          lo = 0;
          hi = 4095;
        end
      endcase
      for (int k = 0; k < run_len && count > 0; k++) begin
        if (region == 5) begin
          sample = $urandom_range(1) ? 12'hFFF : 12'h000;
        end else begin
          sample = DATA_W'($urandom_range(hi, lo));
        end
        queue_item(sample, $urandom);
        count--;
      end
    end
  endtask

  task automatic run_phase(logic [DATA_W-1:0] bright, logic [DATA_W-1:0] dark,
                           int send_pct, int recv_pct, int count);
    write_threshold(REG_BRIGHT, bright);
    write_threshold(REG_DARK, dark);
    n_settings++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(count);
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    logic [DATA_W-1:0] rand_bright;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BRIGHT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the default thresholds, with no idling.
    write_threshold(REG_BRIGHT, 12'd1000);
    write_threshold(REG_DARK, 12'd3000);
    n_settings++;
    // Mean between the thresholds before any change: time stays zero.
    queue_item(12'd2000, 32'h0000_0000);
    // Mean exactly at the bright threshold.
    queue_item(12'd0, 32'hFFFF_FFFF);
    queue_item(12'd4095, 32'hAAAA_AAAA);
    queue_item(12'd4095, 32'h5555_5555);
    queue_item(12'd4095, 32'h0000_0001);
    // Mean exactly at the dark threshold.
    queue_item(12'd3715, 32'h8000_0000);
    // Fill the window and wrap so the oldest sample drops out.
    for (int k = 0; k < 5; k++) begin
      queue_item(12'd4095, $urandom);
    end
    queue_item(12'hAAA, 32'h1234_5678);
    queue_item(12'h555, 32'h8765_4321);
    // Drag the mean down until the level turns bright.
    for (int k = 0; k < 7; k++) begin
      queue_item(12'd0, $urandom);
    end
    queue_item(12'd4095, $urandom);
    queue_item(12'd4095, $urandom);
    drain();

    // Threshold extremes, sender mostly idle.
    run_phase(12'd0, 12'd4095, 82, 0, 100);
    // Overlapping thresholds, receiver mostly stalling.
    run_phase(12'd3000, 12'd1000, 0, 82, 100);
    // Fully overlapping extremes, light pressure on both sides.
    run_phase(12'd4095, 12'd0, 12, 12, 50);
    // Random ordinary thresholds; the sender holds off half way until drained.
    rand_bright = DATA_W'($urandom_range(2500, 200));
    run_phase(rand_bright, DATA_W'($urandom_range(4095, rand_bright)), 12, 12, 75);
    queue_random(75);
    drain();
    // Back to the defaults at full rate.
    run_phase(BRIGHT_RST, DARK_RST, 0, 0, 100);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items through %0d threshold settings; %0d results checked.",
             n_accepted, n_settings, n_results);
    $display("Saw %0d level changes; %0d mismatches.", n_changes, n_errors);
    if (n_errors == 0 && expected_levels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
